[hw/rtl/mdc_pkg.sv]
// Shared types, codes and constants of the depth-first maze carver.
package mdc_pkg;

  // Field widths fixed by the stream and configuration formats.
  localparam int unsigned CFG_W        = 6;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned COORD_W      = 6;
  localparam int unsigned IN_COORD_W   = 5;
  localparam int unsigned CELL_W       = 5;
  localparam int unsigned S_TDATA_W    = 24;
  localparam int unsigned S_TUSER_W    = 2;
  localparam int unsigned M_TDATA_W    = 32;
  localparam int unsigned M_TUSER_W    = 2;

  // Default grid bounds and the register reset value of both dimensions.
  localparam int unsigned DEF_MAX_ROWS = 32;
  localparam int unsigned DEF_MAX_COLS = 32;
  localparam int unsigned CFG_RST_DIM  = 32;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_CONTINUE = 2'd1,
    CMD_READ     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_CARVED   = 2'd0,
    STAT_FINISHED = 2'd1,
    STAT_READ     = 2'd2,
    STAT_ERROR    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_ROWS = 1'b0,
    CFG_ACTIVE_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRY,
    ST_CHECK,
    ST_CARVE,
    ST_POP,
    ST_READ,
    ST_EMIT
  } state_e;

  // Four direction codes, slot 0 in the lowest bits.
  typedef logic [3:0][1:0] dir_order_t;

  localparam dir_order_t DIR_INIT = {2'd3, 2'd2, 2'd1, 2'd0};

  // Cell word: bits 0..3 are the walls in direction order, bit 4 is visited.
  localparam logic [CELL_W-1:0] CELL_RESET   = 5'b01111;
  localparam logic [CELL_W-1:0] CELL_START   = 5'b11111;
  localparam logic [CELL_W-1:0] CELL_VISITED = 5'b10000;
  localparam int unsigned       CELL_VIS_BIT = 4;

  // One stack frame: the cell, its shuffled direction order and the next slot.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    dir_order_t         order;
    logic [2:0]         next;
  } frame_t;

  typedef struct packed {
    status_e                 status;
    logic [IN_COORD_W-1:0]   from_row;
    logic [IN_COORD_W-1:0]   from_col;
    logic [IN_COORD_W-1:0]   to_row;
    logic [IN_COORD_W-1:0]   to_col;
    dir_e                    direction;
    logic [3:0]              walls;
    logic                    visited;
  } result_t;

  localparam result_t RES_ERROR = '{
    status:    STAT_ERROR,
    from_row:  '0,
    from_col:  '0,
    to_row:    '0,
    to_col:    '0,
    direction: DIR_UP,
    walls:     '0,
    visited:   1'b0
  };

  // Swaps slot i with the slot named by draw i, for i = 0..3 in turn.
  function automatic dir_order_t shuffle_dirs(input dir_order_t draws);
    dir_order_t o;
    logic [1:0] t;
    o = DIR_INIT;
    for (int i = 0; i < 4; i++) begin
      t = o[i];
      o[i] = o[draws[i]];
      o[draws[i]] = t;
    end
    return o;
  endfunction

endpackage

[hw/rtl/mdc_ram.sv]
// Single-port-write, single-port-read memory with a registered read.
module mdc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // Write and read in the same clocked block; a read sees the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/mdc_step_unit.sv]
// Shared neighbour unit: steps a cell one way, checks the active grid, forms the address.
module mdc_step_unit import mdc_pkg::*; #(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned AW       = 10
) (
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic               move_i,
  input  dir_e               dir_i,
  input  logic [CFG_W-1:0]   rows_i,
  input  logic [CFG_W-1:0]   cols_i,
  output logic [COORD_W-1:0] nbr_row_o,
  output logic [COORD_W-1:0] nbr_col_o,
  output logic               ok_o,
  output logic [AW-1:0]      addr_o
);

  logic at_edge;

  // Step one cell when asked; otherwise the cell itself is checked.
  always_comb begin
    nbr_row_o = row_i;
    nbr_col_o = col_i;
    at_edge   = 1'b0;
    if (move_i) begin
      unique case (dir_i)
        DIR_UP: begin
          at_edge   = (row_i == '0);
          nbr_row_o = row_i - COORD_W'(1);
        end
        DIR_RIGHT: nbr_col_o = col_i + COORD_W'(1);
        DIR_DOWN:  nbr_row_o = row_i + COORD_W'(1);
        DIR_LEFT: begin
          at_edge   = (col_i == '0);
          nbr_col_o = col_i - COORD_W'(1);
        end
      endcase
    end
  end

  // The cell must lie inside the active part of the grid.
  assign ok_o   = !at_edge && (nbr_row_o < rows_i) && (nbr_col_o < cols_i);
  assign addr_o = AW'(nbr_row_o) * AW'(MAX_COLS) + AW'(nbr_col_o);

endmodule

[hw/rtl/maze_dfs_carver.sv]
// Top level of the randomised depth-first maze carver with its walk sequencer.
// A carve passes through try, check, carve and emit after the step that finds it; a direction
// rejected by the grid check stays in try, a visited neighbour goes through check, a popped frame
// through pop (stack RAM read). A read passes read and emit, an error only emit; one item at a
// time. A start first sweeps all MAX_ROWS*MAX_COLS cells of the store. After reset the same
// sweep runs (all walls up, unvisited) and no item is accepted; config writes are always taken.
module maze_dfs_carver import mdc_pkg::*; #(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // cell_row[4:0], cell_col[9:5], draw0[11:10], draw1[13:12], draw2[15:14], draw3[17:16]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // from_row[4:0], from_col[9:5], to_row[14:10], to_col[19:15], direction[21:20],
  // wall_top[22], wall_right[23], wall_bottom[24], wall_left[25], cell_visited[26]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  localparam int unsigned NCELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned SPW    = $clog2(NCELLS + 1);
  localparam int unsigned FW     = $bits(frame_t);
  localparam logic [CFG_W-1:0] ROWS_RST =
    CFG_W'((MAX_ROWS < CFG_RST_DIM) ? MAX_ROWS : CFG_RST_DIM);
  localparam logic [CFG_W-1:0] COLS_RST =
    CFG_W'((MAX_COLS < CFG_RST_DIM) ? MAX_COLS : CFG_RST_DIM);

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned mx);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > mx) begin
      r = CFG_W'(mx);
    end
    return r;
  endfunction

  // Active grid size
  logic [CFG_W-1:0] rows_q, cols_q;

  // Sequencer state
  state_e           state_q, state_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic             starting_q, starting_d;
  logic [AW-1:0]    walk_addr_q, walk_addr_d;
  logic [SPW-1:0]   count_q, count_d;
  logic             awaiting_q, awaiting_d;
  frame_t           top_q, top_d;
  logic [COORD_W-1:0] nbr_row_q, nbr_row_d, nbr_col_q, nbr_col_d;
  logic [AW-1:0]    nbr_addr_q, nbr_addr_d;
  dir_e             nbr_dir_q, nbr_dir_d;
  result_t          res_q, res_d;
  logic             out_load;

  // Output register
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic [M_TUSER_W-1:0] m_user_q;

  // Shared step unit
  logic [COORD_W-1:0] su_row, su_col, su_nbr_row, su_nbr_col;
  logic               su_move, su_ok;
  dir_e               su_dir;
  logic [AW-1:0]      su_addr;

  // Memory ports
  logic              cell_we;
  logic [AW-1:0]     cell_waddr;
  logic [CELL_W-1:0] cell_wdata, cell_rdata;
  logic              stk_we;
  logic [FW-1:0]     stk_rdata;
  logic [SPW-1:0]    count_m1, count_m2;
  logic [1:0]        opp_dir;

  // Request fields
  logic [IN_COORD_W-1:0] s_row, s_col;
  dir_order_t            s_draws;
  cmd_e                  s_cmd;

  assign s_row   = s_axis_tdata[4:0];
  assign s_col   = s_axis_tdata[9:5];
  assign s_draws = dir_order_t'(s_axis_tdata[17:10]);
  assign s_cmd   = cmd_e'(s_axis_tuser);

  assign count_m1 = count_q - SPW'(1);
  assign count_m2 = count_q - SPW'(2);
  assign opp_dir  = nbr_dir_q ^ 2'b10;

  mdc_step_unit #(
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_step (
    .row_i     (su_row),
    .col_i     (su_col),
    .move_i    (su_move),
    .dir_i     (su_dir),
    .rows_i    (rows_q),
    .cols_i    (cols_q),
    .nbr_row_o (su_nbr_row),
    .nbr_col_o (su_nbr_col),
    .ok_o      (su_ok),
    .addr_o    (su_addr)
  );

  // Cell store: four walls and a visited bit per cell, read at the step unit's address.
  mdc_ram #(
    .DEPTH (NCELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (su_addr),
    .rdata_o (cell_rdata)
  );

  // Frame stack: frames below the top one, which lives in top_q.
  mdc_ram #(
    .DEPTH (NCELLS),
    .AW    (AW),
    .DW    (FW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (count_m1[AW-1:0]),
    .wdata_i (top_q),
    .raddr_i (count_m2[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  // Configuration registers, saturated into the supported range.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ACTIVE_ROWS: rows_q <= clamp_dim(cfg_data_i, MAX_ROWS);
        CFG_ACTIVE_COLS: cols_q <= clamp_dim(cfg_data_i, MAX_COLS);
      endcase
    end
  end

  // Walk sequencer: next state, memory controls and the pending result.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    starting_d  = starting_q;
    walk_addr_d = walk_addr_q;
    count_d     = count_q;
    awaiting_d  = awaiting_q;
    top_d       = top_q;
    nbr_row_d   = nbr_row_q;
    nbr_col_d   = nbr_col_q;
    nbr_addr_d  = nbr_addr_q;
    nbr_dir_d   = nbr_dir_q;
    res_d       = res_q;

    su_row  = top_q.row;
    su_col  = top_q.col;
    su_move = 1'b0;
    su_dir  = dir_e'(top_q.order[top_q.next[1:0]]);

    cell_we       = 1'b0;
    cell_waddr    = su_addr;
    cell_wdata    = CELL_RESET;
    stk_we        = 1'b0;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the whole store back to all walls; on a start, the start cell comes out visited.
        cell_we    = 1'b1;
        cell_waddr = clr_cnt_q;
        cell_wdata = (starting_q && (clr_cnt_q == walk_addr_q)) ? CELL_START : CELL_RESET;
        clr_cnt_d  = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(NCELLS - 1)) begin
          clr_cnt_d  = '0;
          starting_d = 1'b0;
          state_d    = starting_q ? ST_TRY : ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_axis_tready = 1'b1;
        su_row        = COORD_W'(s_row);
        su_col        = COORD_W'(s_col);
        if (s_axis_tvalid) begin
          res_d   = RES_ERROR;
          state_d = ST_EMIT;
          unique case (s_cmd)
            CMD_START: begin
              if (su_ok) begin
                top_d.row   = su_row;
                top_d.col   = su_col;
                top_d.order = shuffle_dirs(s_draws);
                top_d.next  = '0;
                count_d     = SPW'(1);
                awaiting_d  = 1'b0;
                starting_d  = 1'b1;
                walk_addr_d = su_addr;
                state_d     = ST_CLEAR;
              end
            end
            CMD_CONTINUE: begin
              if (awaiting_q && (count_q != '0)) begin
                top_d.order = shuffle_dirs(s_draws);
                top_d.next  = '0;
                awaiting_d  = 1'b0;
                state_d     = ST_TRY;
              end
            end
            CMD_READ: begin
              if (su_ok) begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        res_d         = RES_ERROR;
        res_d.status  = STAT_READ;
        res_d.walls   = cell_rdata[3:0];
        res_d.visited = cell_rdata[CELL_VIS_BIT];
        state_d       = ST_EMIT;
      end

      ST_TRY: begin
        // Try the next slot of the top frame, or pop it when all four are used (finish if it is the last).
        su_move = 1'b1;
        if (top_q.next[2]) begin
          count_d = count_m1;
          if (count_q == SPW'(1)) begin
            awaiting_d   = 1'b0;
            res_d        = RES_ERROR;
            res_d.status = STAT_FINISHED;
            state_d      = ST_EMIT;
          end else begin
            state_d = ST_POP;
          end
        end else begin
          top_d.next = top_q.next + 3'd1;
          if (su_ok) begin
            nbr_row_d  = su_nbr_row;
            nbr_col_d  = su_nbr_col;
            nbr_addr_d = su_addr;
            nbr_dir_d  = su_dir;
            state_d    = ST_CHECK;
          end
        end
      end

      ST_POP: begin
        top_d   = frame_t'(stk_rdata);
        state_d = ST_TRY;
      end

      ST_CHECK: begin
        // Neighbour word is in; the current cell is read for the carve that follows.
        if (cell_rdata[CELL_VIS_BIT]) begin
          state_d = ST_TRY;
        end else begin
          cell_we    = 1'b1;
          cell_waddr = nbr_addr_q;
          cell_wdata = (cell_rdata & ~(CELL_W'(1) << opp_dir)) | CELL_VISITED;
          state_d    = ST_CARVE;
        end
      end

      ST_CARVE: begin
        cell_we    = 1'b1;
        cell_wdata = cell_rdata & ~(CELL_W'(1) << nbr_dir_q);
        if (count_q != SPW'(NCELLS)) begin
          stk_we      = 1'b1;
          top_d.row   = nbr_row_q;
          top_d.col   = nbr_col_q;
          top_d.order = DIR_INIT;
          top_d.next  = '0;
          count_d     = count_q + SPW'(1);
        end
        awaiting_d      = 1'b1;
        res_d           = RES_ERROR;
        res_d.status    = STAT_CARVED;
        res_d.from_row  = top_q.row[IN_COORD_W-1:0];
        res_d.from_col  = top_q.col[IN_COORD_W-1:0];
        res_d.to_row    = nbr_row_q[IN_COORD_W-1:0];
        res_d.to_col    = nbr_col_q[IN_COORD_W-1:0];
        res_d.direction = nbr_dir_q;
        state_d         = ST_EMIT;
      end

      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      starting_q <= 1'b0;
      count_q    <= '0;
      awaiting_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      starting_q <= starting_d;
      count_q    <= count_d;
      awaiting_q <= awaiting_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    walk_addr_q <= walk_addr_d;
    top_q       <= top_d;
    nbr_row_q   <= nbr_row_d;
    nbr_col_q   <= nbr_col_d;
    nbr_addr_q  <= nbr_addr_d;
    nbr_dir_q   <= nbr_dir_d;
    res_q       <= res_d;
    if (out_load) begin
      m_user_q <= res_q.status;
      m_data_q <= {5'b0, res_q.visited, res_q.walls, res_q.direction, res_q.to_col,
                   res_q.to_row, res_q.from_col, res_q.from_row};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The stack never holds more frames than the grid has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SPW'(NCELLS))
    else $error("frame count exceeds the grid size");

  // Draws are only awaited while a frame is on the stack.
  a_await_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (count_q != '0))
    else $error("awaiting draws with an empty stack");

  // A carve always leaves a carved result pending and the walk waiting for draws.
  a_carve_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CARVE) |=> ((state_q == ST_EMIT) && (res_q.status == STAT_CARVED)
                               && awaiting_q))
    else $error("carve did not produce a carved result");

  // A finished result only goes out once the stack has run empty.
  a_finish_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && (res_q.status == STAT_FINISHED))
      |-> ((count_q == '0) && !awaiting_q))
    else $error("walk finished with frames left on the stack");

endmodule
